/* rtl/rac_pkg.sv */
// ----------------------------------------------------------------------------
// rac_pkg
// Shared types, constants and helpers for the rgb alpha compositor.
// ----------------------------------------------------------------------------
package rac_pkg;

    localparam int SCREEN_WIDTH_DEF  = 320;
    localparam int SCREEN_HEIGHT_DEF = 240;

    localparam int COL_W   = 9;
    localparam int ROW_W   = 8;
    localparam int CH_W    = 8;
    localparam int PIX_W   = 24;
    localparam int POS_W   = 11;   // holds any screen dimension up to 2047
    localparam int PADDR_W = 5;
    localparam int PDATA_W = 32;
    localparam int SUM_W   = 16;

    localparam logic [CH_W-1:0] CH_MAX = 8'd255;

    typedef enum logic
    {
        KIND_BG_WRITE = 1'b0,
        KIND_BLEND    = 1'b1
    } kind_t;

    typedef enum logic [2:0]
    {
        REG_FG_RED         = 3'd0,
        REG_FG_GREEN       = 3'd1,
        REG_FG_BLUE        = 3'd2,
        REG_FIXED_BG_RED   = 3'd3,
        REG_FIXED_BG_GREEN = 3'd4,
        REG_FIXED_BG_BLUE  = 3'd5,
        REG_USE_FIXED_BG   = 3'd6
    } reg_idx_t;

    typedef struct packed
    {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
    } rgb_t;

    typedef struct packed
    {
        rgb_t fg;
        rgb_t fixed_bg;
        logic use_fixed_bg;
    } cfg_t;

    // position and sideband that travel with a blend item
    typedef struct packed
    {
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
        rgb_t             alpha;
        logic             last;
    } blend_tag_t;

    typedef struct packed
    {
        kind_t            kind;
        blend_tag_t       tag;
        logic             on_screen;
        logic [PIX_W-1:0] wpix;
    } s1_item_t;

    typedef struct packed
    {
        blend_tag_t       tag;
        logic             on_screen;
        logic [PIX_W-1:0] pix;
    } s2_item_t;

    // exact floor(x/255) for x below 65280
    function automatic logic [CH_W-1:0] div255(input logic [SUM_W-1:0] x);
        logic [SUM_W:0] t;
        t = {1'b0, x} + {9'd0, x[SUM_W-1:8]} + 17'd1;
        return t[15:8];
    endfunction

endpackage

/* rtl/rac_if.sv */
// ----------------------------------------------------------------------------
// rac_in_if / rac_out_if
// Valid/ready channels for the compositor input items and result pixels.
// ----------------------------------------------------------------------------
interface rac_in_if;
    logic                      valid;
    logic                      ready;
    logic                      kind;
    logic [rac_pkg::COL_W-1:0] pixel_col;
    logic [rac_pkg::ROW_W-1:0] pixel_row;
    logic [rac_pkg::CH_W-1:0]  alpha_red;
    logic [rac_pkg::CH_W-1:0]  alpha_green;
    logic [rac_pkg::CH_W-1:0]  alpha_blue;
    logic [rac_pkg::PIX_W-1:0] bg_write_pixel;
    logic                      last_pixel;

    modport source
    (
        output valid, kind, pixel_col, pixel_row, alpha_red, alpha_green,
               alpha_blue, bg_write_pixel, last_pixel,
        input  ready
    );
    modport sink
    (
        input  valid, kind, pixel_col, pixel_row, alpha_red, alpha_green,
               alpha_blue, bg_write_pixel, last_pixel,
        output ready
    );
endinterface

interface rac_out_if;
    logic                      valid;
    logic                      ready;
    logic [rac_pkg::CH_W-1:0]  out_red;
    logic [rac_pkg::CH_W-1:0]  out_green;
    logic [rac_pkg::CH_W-1:0]  out_blue;
    logic [rac_pkg::COL_W-1:0] out_col;
    logic [rac_pkg::ROW_W-1:0] out_row;
    logic                      out_last;

    modport source
    (
        output valid, out_red, out_green, out_blue, out_col, out_row, out_last,
        input  ready
    );
    modport sink
    (
        input  valid, out_red, out_green, out_blue, out_col, out_row, out_last,
        output ready
    );
endinterface

/* rtl/rac_addr.sv */
// ----------------------------------------------------------------------------
// rac_addr
// Input stage: range check and column-major frame store address.
// ----------------------------------------------------------------------------
module rac_addr #(
    parameter int SCREEN_WIDTH  = rac_pkg::SCREEN_WIDTH_DEF,
    parameter int SCREEN_HEIGHT = rac_pkg::SCREEN_HEIGHT_DEF,
    parameter int ADDR_W        = 17
) (
    input  logic              clk,
    input  logic              rst_n,
    rac_in_if.sink            pix_in,
    input  logic              s1_ready,
    output logic              s1_valid,
    output rac_pkg::s1_item_t s1_item,
    output logic [ADDR_W-1:0] s1_addr
);

    logic              s1_valid_reg;
    logic              s1_valid_next;
    rac_pkg::s1_item_t s1_item_reg;
    rac_pkg::s1_item_t s1_item_next;
    logic [ADDR_W-1:0] s1_addr_reg;
    logic [ADDR_W-1:0] s1_addr_next;
    logic              en;
    logic [31:0]       lin;

    assign en           = !s1_valid_reg || s1_ready;
    assign pix_in.ready = en;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (en)
        begin
            s1_valid_next = pix_in.valid;
        end

        s1_item_next.kind            = rac_pkg::kind_t'(pix_in.kind);
        s1_item_next.tag.col         = pix_in.pixel_col;
        s1_item_next.tag.row         = pix_in.pixel_row;
        s1_item_next.tag.alpha.red   = pix_in.alpha_red;
        s1_item_next.tag.alpha.green = pix_in.alpha_green;
        s1_item_next.tag.alpha.blue  = pix_in.alpha_blue;
        s1_item_next.tag.last        = pix_in.last_pixel;
        s1_item_next.wpix            = pix_in.bg_write_pixel;
        s1_item_next.on_screen =
            (rac_pkg::POS_W'(pix_in.pixel_col) < rac_pkg::POS_W'(SCREEN_WIDTH)) &&
            (rac_pkg::POS_W'(pix_in.pixel_row) < rac_pkg::POS_W'(SCREEN_HEIGHT));

        // column-major: col*height + row
        lin = 32'(pix_in.pixel_col) * 32'(SCREEN_HEIGHT) + 32'(pix_in.pixel_row);
        s1_addr_next = s1_item_next.on_screen ? lin[ADDR_W-1:0] : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_item_reg <= s1_item_next;
            s1_addr_reg <= s1_addr_next;
        end
    end

    assign s1_valid = s1_valid_reg;
    assign s1_item  = s1_item_reg;
    assign s1_addr  = s1_addr_reg;

endmodule

/* rtl/rac_store.sv */
// ----------------------------------------------------------------------------
// rac_store
// Frame store stage: one write or one registered read per beat.
// ----------------------------------------------------------------------------
module rac_store #(
    parameter int DEPTH  = rac_pkg::SCREEN_WIDTH_DEF * rac_pkg::SCREEN_HEIGHT_DEF,
    parameter int ADDR_W = 17
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s1_valid,
    input  rac_pkg::s1_item_t s1_item,
    input  logic [ADDR_W-1:0] s1_addr,
    output logic              s1_ready,
    output logic              s2_valid,
    output rac_pkg::s2_item_t s2_item,
    input  logic              s2_ready
);

    logic [rac_pkg::PIX_W-1:0] store_reg [DEPTH];
    logic [rac_pkg::PIX_W-1:0] pix_reg;
    logic                      s2_valid_reg;
    logic                      s2_valid_next;
    rac_pkg::blend_tag_t       tag_reg;
    logic                      on_screen_reg;
    logic                      en;
    logic                      wr_en;

    assign en       = !s2_valid_reg || s2_ready;
    assign s1_ready = en;
    assign wr_en    = en && s1_valid && (s1_item.kind == rac_pkg::KIND_BG_WRITE) &&
                      s1_item.on_screen;

    // background writes end here
    always_comb
    begin
        s2_valid_next = s2_valid_reg;
        if (en)
        begin
            s2_valid_next = s1_valid && (s1_item.kind == rac_pkg::KIND_BLEND);
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            store_reg[s1_addr] <= s1_item.wpix;
        end
        if (en)
        begin
            pix_reg <= store_reg[s1_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s2_valid_reg <= s2_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            tag_reg       <= s1_item.tag;
            on_screen_reg <= s1_item.on_screen;
        end
    end

    assign s2_valid          = s2_valid_reg;
    assign s2_item.tag       = tag_reg;
    assign s2_item.on_screen = on_screen_reg;
    assign s2_item.pix       = pix_reg;

endmodule

/* rtl/rac_mix.sv */
// ----------------------------------------------------------------------------
// rac_mix
// Blend stages: per-channel weighted sum, then divide by 255 into the
// output register.
// ----------------------------------------------------------------------------
module rac_mix (
    input  logic              clk,
    input  logic              rst_n,
    input  rac_pkg::cfg_t     cfg,
    input  logic              s2_valid,
    input  rac_pkg::s2_item_t s2_item,
    output logic              s2_ready,
    rac_out_if.source         pix_out
);

    typedef struct packed
    {
        logic [rac_pkg::SUM_W-1:0] red;
        logic [rac_pkg::SUM_W-1:0] green;
        logic [rac_pkg::SUM_W-1:0] blue;
    } sum_t;

    logic                s3_valid_reg;
    logic                s3_valid_next;
    sum_t                s3_sum_reg;
    sum_t                s3_sum_next;
    rac_pkg::blend_tag_t s3_tag_reg;
    logic                out_valid_reg;
    logic                out_valid_next;
    rac_pkg::rgb_t       out_rgb_reg;
    rac_pkg::rgb_t       out_rgb_next;
    rac_pkg::blend_tag_t out_tag_reg;
    rac_pkg::rgb_t       bg;
    logic                en3;
    logic                en4;

    function automatic logic [rac_pkg::SUM_W-1:0] wsum(
        input logic [rac_pkg::CH_W-1:0] a,
        input logic [rac_pkg::CH_W-1:0] fg,
        input logic [rac_pkg::CH_W-1:0] b
    );
        logic [rac_pkg::SUM_W-1:0] p_fg;
        logic [rac_pkg::SUM_W-1:0] p_bg;
        p_fg = rac_pkg::SUM_W'(a) * rac_pkg::SUM_W'(fg);
        p_bg = (rac_pkg::SUM_W'(rac_pkg::CH_MAX) - rac_pkg::SUM_W'(a)) * rac_pkg::SUM_W'(b);
        return p_fg + p_bg;
    endfunction

    assign en4      = !out_valid_reg || pix_out.ready;
    assign en3      = !s3_valid_reg || en4;
    assign s2_ready = en3;

    always_comb
    begin
        if (cfg.use_fixed_bg)
        begin
            bg = cfg.fixed_bg;
        end
        else if (s2_item.on_screen)
        begin
            bg = rac_pkg::rgb_t'(s2_item.pix);
        end
        else
        begin
            bg = '0;
        end

        s3_sum_next.red   = wsum(s2_item.tag.alpha.red,   cfg.fg.red,   bg.red);
        s3_sum_next.green = wsum(s2_item.tag.alpha.green, cfg.fg.green, bg.green);
        s3_sum_next.blue  = wsum(s2_item.tag.alpha.blue,  cfg.fg.blue,  bg.blue);

        s3_valid_next = en3 ? s2_valid : s3_valid_reg;

        out_rgb_next.red   = rac_pkg::div255(s3_sum_reg.red);
        out_rgb_next.green = rac_pkg::div255(s3_sum_reg.green);
        out_rgb_next.blue  = rac_pkg::div255(s3_sum_reg.blue);

        out_valid_next = en4 ? s3_valid_reg : out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s3_valid_reg  <= s3_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en3)
        begin
            s3_sum_reg <= s3_sum_next;
            s3_tag_reg <= s2_item.tag;
        end
        if (en4)
        begin
            out_rgb_reg <= out_rgb_next;
            out_tag_reg <= s3_tag_reg;
        end
    end

    assign pix_out.valid     = out_valid_reg;
    assign pix_out.out_red   = out_rgb_reg.red;
    assign pix_out.out_green = out_rgb_reg.green;
    assign pix_out.out_blue  = out_rgb_reg.blue;
    assign pix_out.out_col   = out_tag_reg.col;
    assign pix_out.out_row   = out_tag_reg.row;
    assign pix_out.out_last  = out_tag_reg.last;

endmodule

/* rtl/rgb_alpha_compositor.sv */
// ----------------------------------------------------------------------------
// rgb_alpha_compositor
// Per-pixel alpha blend of a sprite colour over a stored or fixed background.
// ----------------------------------------------------------------------------
// Takes one item per clock, back to back, for as long as results are taken: a
// background write or a blend enters whenever the first stage is free, and a
// held result stalls the input only once the four stages are full. A blend
// result passes one register each for address, frame store read, weighted
// sum and divide by 255 into the output register. The single-port frame store
// (width*height entries of 24 bits, no reset, no clearing pass) reads and
// writes at one address per clock, and that sets the rate of one item per
// clock. Writes give no result. A blend that takes its background from a store
// entry never written returns an undefined colour.
module rgb_alpha_compositor #(
    parameter int SCREEN_WIDTH  = rac_pkg::SCREEN_WIDTH_DEF,
    parameter int SCREEN_HEIGHT = rac_pkg::SCREEN_HEIGHT_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    rac_in_if.sink                      pix_in,
    rac_out_if.source                   pix_out,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [rac_pkg::PADDR_W-1:0] paddr,
    input  logic [rac_pkg::PDATA_W-1:0] pwdata,
    output logic [rac_pkg::PDATA_W-1:0] prdata,
    output logic                        pready
);

    localparam int DEPTH  = SCREEN_WIDTH * SCREEN_HEIGHT;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    rac_pkg::cfg_t     cfg_reg;
    rac_pkg::cfg_t     cfg_next;
    rac_pkg::reg_idx_t reg_idx;
    logic              cfg_wr;

    logic              s1_valid;
    logic              s1_ready;
    rac_pkg::s1_item_t s1_item;
    logic [ADDR_W-1:0] s1_addr;
    logic              s2_valid;
    logic              s2_ready;
    rac_pkg::s2_item_t s2_item;

    assign pready  = 1'b1;
    assign reg_idx = rac_pkg::reg_idx_t'(paddr[4:2]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr)
        begin
            unique case (reg_idx)
                rac_pkg::REG_FG_RED:         cfg_next.fg.red         = pwdata[7:0];
                rac_pkg::REG_FG_GREEN:       cfg_next.fg.green       = pwdata[7:0];
                rac_pkg::REG_FG_BLUE:        cfg_next.fg.blue        = pwdata[7:0];
                rac_pkg::REG_FIXED_BG_RED:   cfg_next.fixed_bg.red   = pwdata[7:0];
                rac_pkg::REG_FIXED_BG_GREEN: cfg_next.fixed_bg.green = pwdata[7:0];
                rac_pkg::REG_FIXED_BG_BLUE:  cfg_next.fixed_bg.blue  = pwdata[7:0];
                rac_pkg::REG_USE_FIXED_BG:   cfg_next.use_fixed_bg   = pwdata[0];
                default:                     cfg_next                = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            rac_pkg::REG_FG_RED:         prdata = 32'(cfg_reg.fg.red);
            rac_pkg::REG_FG_GREEN:       prdata = 32'(cfg_reg.fg.green);
            rac_pkg::REG_FG_BLUE:        prdata = 32'(cfg_reg.fg.blue);
            rac_pkg::REG_FIXED_BG_RED:   prdata = 32'(cfg_reg.fixed_bg.red);
            rac_pkg::REG_FIXED_BG_GREEN: prdata = 32'(cfg_reg.fixed_bg.green);
            rac_pkg::REG_FIXED_BG_BLUE:  prdata = 32'(cfg_reg.fixed_bg.blue);
            rac_pkg::REG_USE_FIXED_BG:   prdata = 32'(cfg_reg.use_fixed_bg);
            default:                     prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.fg           <= '{red: 8'd255, green: 8'd255, blue: 8'd255};
            cfg_reg.fixed_bg     <= '0;
            cfg_reg.use_fixed_bg <= 1'b0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    rac_addr #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT),
        .ADDR_W        (ADDR_W)
    ) u_addr (
        .clk      (clk),
        .rst_n    (rst_n),
        .pix_in   (pix_in),
        .s1_ready (s1_ready),
        .s1_valid (s1_valid),
        .s1_item  (s1_item),
        .s1_addr  (s1_addr)
    );

    rac_store #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_store (
        .clk      (clk),
        .rst_n    (rst_n),
        .s1_valid (s1_valid),
        .s1_item  (s1_item),
        .s1_addr  (s1_addr),
        .s1_ready (s1_ready),
        .s2_valid (s2_valid),
        .s2_item  (s2_item),
        .s2_ready (s2_ready)
    );

    rac_mix u_mix (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .s2_valid (s2_valid),
        .s2_item  (s2_item),
        .s2_ready (s2_ready),
        .pix_out  (pix_out)
    );

    // input only backs up when the first stage holds an item
    a_ready_low_means_full: assert property (
        @(posedge clk) disable iff (!rst_n)
        !pix_in.ready |-> s1_valid
    ) else $error("input stalled with an empty first stage");

    // a stalled first stage keeps its item and address
    a_s1_hold: assert property (
        @(posedge clk) disable iff (!rst_n)
        s1_valid && !s1_ready |=> s1_valid && $stable(s1_addr) && $stable(s1_item)
    ) else $error("first stage lost or changed a stalled item");

    // foreground red write lands in the register
    a_cfg_fg_red: assert property (
        @(posedge clk) disable iff (!rst_n)
        cfg_wr && (reg_idx == rac_pkg::REG_FG_RED) |=> cfg_reg.fg.red == $past(pwdata[7:0])
    ) else $error("foreground red write not taken");

endmodule
